// ----- design/mvt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvt_pkg
// Shared types and constants of the 4x4 matrix-vector transform pipeline.
// ----------------------------------------------------------------------------
package mvt_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int NUM_DIM   = 4;
   localparam int NUM_REGS  = 8;
   localparam int CSR_W     = 64;
   localparam int CSR_IDX_W = 3;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int PAIR_W    = PROD_W + 1;
   localparam int SUM_W     = PROD_W + 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_COL1_ROWS01 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COL1_ROWS23 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COL2_ROWS01 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COL2_ROWS23 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_COL3_ROWS01 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_COL3_ROWS23 = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_COL4_ROWS01 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_COL4_ROWS23 = 3'd7;

   // identity entry (1.0) in the low or high half of a register
   localparam logic [CSR_W-1:0] ONE_LO = CSR_W'(64'h0000_0000_0001_0000);
   localparam logic [CSR_W-1:0] ONE_HI = CSR_W'(64'h0001_0000_0000_0000);

   typedef logic signed [DATA_W-1:0] entry_type;
   typedef entry_type [NUM_DIM-1:0]  vec_type;
   typedef vec_type [NUM_DIM-1:0]    mat_type;   // [row][col]

   typedef logic signed [PROD_W-1:0] prod_type;
   typedef prod_type [NUM_DIM-1:0]   prod_row_type;
   typedef prod_row_type [NUM_DIM-1:0] prod_mat_type;

   typedef logic signed [PAIR_W-1:0] pair_type;
   typedef pair_type [1:0]           pair_row_type;
   typedef pair_row_type [NUM_DIM-1:0] pair_mat_type;

   typedef logic signed [SUM_W-1:0]  sum_type;
   typedef sum_type [NUM_DIM-1:0]    sum_vec_type;

   localparam entry_type ENTRY_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam entry_type ENTRY_MIN = {1'b1, {(DATA_W-1){1'b0}}};

endpackage

// ----- design/matrix_vector_transform_4x4.sv -----
// pipeline of four register stages (multiply, pair add, row add, shift/saturate);
// accepted data then passes the pair, row and output registers to rsp_valid
// throughput: one vector per cycle; every stage advances when the next has room
// reset: synchronous, active high; empties the pipeline, matrix back to identity
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_vector_transform_4x4
// Q16.16 homogeneous 4x4 matrix times vector, saturated, pipelined.
// ----------------------------------------------------------------------------
module matrix_vector_transform_4x4
   import mvt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wr_data,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic signed [DATA_W-1:0] req_vec_x,
   input  logic signed [DATA_W-1:0] req_vec_y,
   input  logic signed [DATA_W-1:0] req_vec_z,
   input  logic signed [DATA_W-1:0] req_vec_w,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic signed [DATA_W-1:0] rsp_out_0,
   output logic signed [DATA_W-1:0] rsp_out_1,
   output logic signed [DATA_W-1:0] rsp_out_2,
   output logic signed [DATA_W-1:0] rsp_out_3,
   output logic                 rsp_clipped
);

   mat_type      matrix;
   vec_type      vec;
   prod_mat_type prod;
   logic         prod_valid;
   logic         prod_ready;
   sum_vec_type  sum;
   logic         sum_valid;
   logic         sum_ready;
   vec_type      result;

   assign vec[0] = req_vec_x;
   assign vec[1] = req_vec_y;
   assign vec[2] = req_vec_z;
   assign vec[3] = req_vec_w;

   mvt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .matrix      (matrix)
   );

   mvt_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .vec       (vec),
      .matrix    (matrix),
      .out_valid (prod_valid),
      .out_ready (prod_ready),
      .prod      (prod)
   );

   mvt_sum u_sum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prod_valid),
      .in_ready  (prod_ready),
      .prod      (prod),
      .out_valid (sum_valid),
      .out_ready (sum_ready),
      .sum       (sum)
   );

   mvt_sat u_sat (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sum_valid),
      .in_ready  (sum_ready),
      .sum       (sum),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .result    (result),
      .clipped   (rsp_clipped)
   );

   assign rsp_out_0 = result[0];
   assign rsp_out_1 = result[1];
   assign rsp_out_2 = result[2];
   assign rsp_out_3 = result[3];

endmodule

// ----- design/mvt_csr.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvt_csr
// Matrix register file: eight 64-bit registers, two Q16.16 entries each.
// ----------------------------------------------------------------------------
module mvt_csr
   import mvt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wr_data,
   output mat_type              matrix
);

   logic [CSR_W-1:0] regs_ff [NUM_REGS];

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff[REG_COL1_ROWS01] <= ONE_LO;
         regs_ff[REG_COL1_ROWS23] <= '0;
         regs_ff[REG_COL2_ROWS01] <= ONE_HI;
         regs_ff[REG_COL2_ROWS23] <= '0;
         regs_ff[REG_COL3_ROWS01] <= '0;
         regs_ff[REG_COL3_ROWS23] <= ONE_LO;
         regs_ff[REG_COL4_ROWS01] <= '0;
         regs_ff[REG_COL4_ROWS23] <= ONE_HI;
      end else if (csr_wr_en) begin
         regs_ff[csr_index] <= csr_wr_data;
      end
   end

   // column c, rows 2k/2k+1 live in register 2c+k; odd rows in the high half
   always_comb begin
      for (int r = 0; r < NUM_DIM; r++) begin
         for (int c = 0; c < NUM_DIM; c++) begin
            if (r % 2 == 1) begin
               matrix[r][c] = regs_ff[c*2 + r/2][CSR_W-1:DATA_W];
            end else begin
               matrix[r][c] = regs_ff[c*2 + r/2][DATA_W-1:0];
            end
         end
      end
   end

endmodule

// ----- design/mvt_mult.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvt_mult
// Product stage: sixteen 32x32 signed multiplies, results registered.
// ----------------------------------------------------------------------------
module mvt_mult
   import mvt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  vec_type      vec,
   input  mat_type      matrix,
   output logic         out_valid,
   input  logic         out_ready,
   output prod_mat_type prod
);

   logic         valid_ff;
   prod_mat_type prod_ff;
   prod_mat_type prod_in;

   always_comb begin
      for (int r = 0; r < NUM_DIM; r++) begin
         for (int c = 0; c < NUM_DIM; c++) begin
            prod_in[r][c] = prod_type'(vec[c]) * prod_type'(matrix[r][c]);
         end
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign prod      = prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         prod_ff <= prod_in;
      end
   end

endmodule

// ----- design/mvt_sum.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvt_sum
// Two-level registered adder tree: pairs of products, then the row sum.
// ----------------------------------------------------------------------------
module mvt_sum
   import mvt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  prod_mat_type prod,
   output logic         out_valid,
   input  logic         out_ready,
   output sum_vec_type  sum
);

   logic         pair_valid_ff;
   logic         pair_ready;
   pair_mat_type pair_ff;
   pair_mat_type pair_in;
   logic         sum_valid_ff;
   sum_vec_type  sum_ff;
   sum_vec_type  sum_in;

   always_comb begin
      for (int r = 0; r < NUM_DIM; r++) begin
         pair_in[r][0] = PAIR_W'(prod[r][0]) + PAIR_W'(prod[r][1]);
         pair_in[r][1] = PAIR_W'(prod[r][2]) + PAIR_W'(prod[r][3]);
         sum_in[r]     = SUM_W'(pair_ff[r][0]) + SUM_W'(pair_ff[r][1]);
      end
   end

   assign pair_ready = !sum_valid_ff || out_ready;
   assign in_ready   = !pair_valid_ff || pair_ready;
   assign out_valid  = sum_valid_ff;
   assign sum        = sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_valid_ff <= 1'b0;
         sum_valid_ff  <= 1'b0;
      end else begin
         if (in_ready) begin
            pair_valid_ff <= in_valid;
         end
         if (pair_ready) begin
            sum_valid_ff <= pair_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         pair_ff <= pair_in;
      end
      if (pair_ready && pair_valid_ff) begin
         sum_ff <= sum_in;
      end
   end

endmodule

// ----- design/mvt_sat.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvt_sat
// Output stage: arithmetic shift by the fraction bits, saturate to 32 bits.
// ----------------------------------------------------------------------------
module mvt_sat
   import mvt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  sum_vec_type sum,
   output logic        out_valid,
   input  logic        out_ready,
   output vec_type     result,
   output logic        clipped
);

   logic    valid_ff;
   vec_type result_ff;
   vec_type result_in;
   logic    clipped_ff;
   logic    clipped_in;

   always_comb begin
      sum_type                  shifted;
      logic [SUM_W-DATA_W:0]    upper;
      clipped_in = 1'b0;
      for (int r = 0; r < NUM_DIM; r++) begin
         shifted = sum[r] >>> FRAC_BITS;
         upper   = shifted[SUM_W-1:DATA_W-1];
         // fits when the bits above the 32-bit sign are all sign copies
         if ((&upper) || !(|upper)) begin
            result_in[r] = shifted[DATA_W-1:0];
         end else begin
            result_in[r] = shifted[SUM_W-1] ? ENTRY_MIN : ENTRY_MAX;
            clipped_in   = 1'b1;
         end
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign result    = result_ff;
   assign clipped   = clipped_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         result_ff  <= result_in;
         clipped_ff <= clipped_in;
      end
   end

endmodule
